// ===== rtl/htw_pkg.sv =====
// htw_pkg: shared constants, codes and controller/datapath command and status types
// for the hierarchical timer wheel. No dependencies.
`default_nettype none

package htw_pkg;

  localparam int MAX_TIMERS_DEF = 32;
  localparam int GEN_BITS_DEF   = 8;
  localparam int COUNT_BITS_DEF = 32;

  localparam int ID_W  = 13;
  localparam int DUR_W = 32;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_ADD  = 2'd1;
  localparam logic [1:0] ACT_DEL  = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [2:0] EV_ADDED          = 3'd0;
  localparam logic [2:0] EV_ADD_REFUSED    = 3'd1;
  localparam logic [2:0] EV_DELETED        = 3'd2;
  localparam logic [2:0] EV_DELETE_REFUSED = 3'd3;
  localparam logic [2:0] EV_EXPIRED        = 3'd4;
  localparam logic [2:0] EV_TICK_DONE      = 3'd5;

  typedef enum logic [2:0] {
    WR_NONE  = 3'd0,
    WR_CLEAR = 3'd1,
    WR_ALLOC = 3'd2,
    WR_FREE  = 3'd3,
    WR_REARM = 3'd4
  } wr_op_t;

  typedef enum logic [1:0] {
    ID_SLOT  = 2'd0,
    ID_INPUT = 2'd1,
    ID_ZERO  = 2'd2
  } id_sel_t;

  typedef struct packed {
    logic       take;
    logic       idx_zero;
    logic       idx_del;
    logic       idx_step;
    logic       rd_en;
    wr_op_t     wr;
    logic       emit;
    logic [2:0] kind;
    id_sel_t    id_sel;
    logic       last;
    logic       tick_step;
  } htw_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_act;
    logic [1:0] act;
    logic       live;
    logic       rpt;
    logic       hit;
    logic       gen_ok;
    logic       slot_ok;
    logic       scan_last;
    logic       clr_last;
    logic       out_free;
  } htw_stat_t;

endpackage

`default_nettype wire

// ===== rtl/htw_if.sv =====
// htw_in_if / htw_out_if: valid/ready channels for request words and event words
// of the timer wheel. No dependencies.
`default_nettype none

interface htw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] duration_ticks;
  logic        repeat_req;
  logic [12:0] timer_id;

  modport source (output valid, output action, output duration_ticks, output repeat_req,
                  output timer_id, input ready);
  modport sink (input valid, input action, input duration_ticks, input repeat_req,
                input timer_id, output ready);
endinterface

interface htw_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] result_id;
  logic [2:0]  event_kind;
  logic        last;

  modport source (output valid, output result_id, output event_kind, output last,
                  input ready);
  modport sink (input valid, input result_id, input event_kind, input last,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/htw_ctrl.sv =====
// htw_ctrl: sequencing state machine of the timer wheel (clear, dispatch, slot scan).
// Depends on htw_pkg.
`default_nettype none

module htw_ctrl import htw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  htw_stat_t stat,
  output htw_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.wr       = WR_CLEAR;
        cmd.idx_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.take = 1'b1;
        if (stat.in_valid) begin
          unique case (stat.in_act) inside
            ACT_TICK, ACT_ADD: begin
              cmd.idx_zero = 1'b1;
              state_next   = S_READ;
            end
            ACT_DEL: begin
              cmd.idx_del = 1'b1;
              state_next  = S_READ;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        case (stat.act)
          ACT_TICK: begin
            if (stat.live && stat.hit) begin
              if (stat.out_free) begin
                cmd.emit   = 1'b1;
                cmd.kind   = EV_EXPIRED;
                cmd.id_sel = ID_SLOT;
                cmd.wr     = stat.rpt ? WR_REARM : WR_FREE;
                if (stat.scan_last) begin
                  state_next = S_DONE;
                end else begin
                  cmd.rd_en = 1'b1;
                end
              end
            end else if (stat.scan_last) begin
              state_next = S_DONE;
            end else begin
              cmd.rd_en = 1'b1;
            end
          end
          ACT_ADD: begin
            if (!stat.live) begin
              if (stat.out_free) begin
                cmd.emit   = 1'b1;
                cmd.kind   = EV_ADDED;
                cmd.id_sel = ID_SLOT;
                cmd.last   = 1'b1;
                cmd.wr     = WR_ALLOC;
                state_next = S_IDLE;
              end
            end else if (stat.scan_last) begin
              if (stat.out_free) begin
                cmd.emit   = 1'b1;
                cmd.kind   = EV_ADD_REFUSED;
                cmd.id_sel = ID_ZERO;
                cmd.last   = 1'b1;
                state_next = S_IDLE;
              end
            end else begin
              cmd.rd_en = 1'b1;
            end
          end
          ACT_DEL: begin
            if (stat.out_free) begin
              cmd.emit   = 1'b1;
              cmd.id_sel = ID_INPUT;
              cmd.last   = 1'b1;
              state_next = S_IDLE;
              if (stat.slot_ok && stat.live && stat.gen_ok) begin
                cmd.kind = EV_DELETED;
                cmd.wr   = WR_FREE;
              end else begin
                cmd.kind = EV_DELETE_REFUSED;
              end
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = EV_TICK_DONE;
          cmd.id_sel    = ID_ZERO;
          cmd.last      = 1'b1;
          cmd.tick_step = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/htw_dp.sv =====
// htw_dp: slot table memory, scan index, tick counter, request capture and event
// output register of the timer wheel. Depends on htw_pkg and htw_if.
`default_nettype none

module htw_dp import htw_pkg::*; #(
  parameter int MAX_TIMERS = MAX_TIMERS_DEF,
  parameter int GEN_BITS   = GEN_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  htw_in_if.sink    req,
  htw_out_if.source evt,
  input  htw_cmd_t  cmd,
  output htw_stat_t stat
);

  localparam int          IDX_W       = $clog2(MAX_TIMERS);
  localparam logic [31:0] COUNT_MAX32 = 32'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [31:0] GEN_MASK32  = 32'((64'd1 << GEN_BITS) - 64'd1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TIMERS - 1);

  // slot table
  logic                  mem_live   [MAX_TIMERS];
  logic                  mem_rpt    [MAX_TIMERS];
  logic [GEN_BITS-1:0]   mem_gen    [MAX_TIMERS];
  logic [COUNT_BITS-1:0] mem_period [MAX_TIMERS];
  logic [COUNT_BITS-1:0] mem_expiry [MAX_TIMERS];

  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_live;
  logic                  rd_rpt;
  logic [GEN_BITS-1:0]   rd_gen;
  logic [COUNT_BITS-1:0] rd_period;
  logic [COUNT_BITS-1:0] rd_expiry;

  logic [1:0]            act_q;
  logic [COUNT_BITS-1:0] dur_q;
  logic                  rpt_q;
  logic [ID_W-1:0]       tid_q;
  logic [COUNT_BITS-1:0] tick_count;

  logic                  out_valid;
  logic [ID_W-1:0]       out_id;
  logic [2:0]            out_kind;
  logic                  out_last;

  logic [31:0]           req_slot32;
  logic [31:0]           tid32;
  logic [31:0]           dur_in;
  logic [31:0]           dur_c;
  logic [31:0]           slot_id32;
  logic [COUNT_BITS-1:0] add_op;
  logic [COUNT_BITS-1:0] exp_new;
  logic [ID_W-1:0]       id_sel;
  logic                  accept;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic                  w_live;
  logic                  w_rpt;
  logic [GEN_BITS-1:0]   w_gen;
  logic [COUNT_BITS-1:0] w_period;
  logic [COUNT_BITS-1:0] w_expiry;

  assign accept     = cmd.take && req.valid;
  assign req.ready  = cmd.take;
  assign req_slot32 = 32'(req.timer_id) >> GEN_BITS;
  assign tid32      = 32'(tid_q);
  assign dur_in     = req.duration_ticks;
  assign dur_c      = (dur_in == 32'd0) ? 32'd1 :
                      ((dur_in > COUNT_MAX32) ? COUNT_MAX32 : dur_in);
  assign slot_id32  = (32'(rd_idx) << GEN_BITS) | 32'(rd_gen);
  assign add_op     = (cmd.wr == WR_ALLOC) ? dur_q : rd_period;
  assign exp_new    = tick_count + add_op;

  always_comb begin
    case (cmd.id_sel)
      ID_SLOT:  id_sel = slot_id32[ID_W-1:0];
      ID_INPUT: id_sel = tid_q;
      default:  id_sel = '0;
    endcase
  end

  assign we    = (cmd.wr != WR_NONE);
  assign waddr = (cmd.wr == WR_CLEAR) ? idx : rd_idx;

  always_comb begin
    w_live   = rd_live;
    w_rpt    = rd_rpt;
    w_gen    = rd_gen;
    w_period = rd_period;
    w_expiry = rd_expiry;
    case (cmd.wr)
      WR_CLEAR: begin
        w_live   = 1'b0;
        w_rpt    = 1'b0;
        w_gen    = '0;
        w_period = '0;
        w_expiry = '0;
      end
      WR_ALLOC: begin
        w_live   = 1'b1;
        w_rpt    = rpt_q;
        w_period = dur_q;
        w_expiry = exp_new;
      end
      WR_FREE: begin
        w_live = 1'b0;
        w_rpt  = 1'b0;
        w_gen  = rd_gen + GEN_BITS'(1);
      end
      WR_REARM: begin
        w_expiry = exp_new;
      end
      default: begin
        w_live = rd_live;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_live[waddr]   <= w_live;
      mem_rpt[waddr]    <= w_rpt;
      mem_gen[waddr]    <= w_gen;
      mem_period[waddr] <= w_period;
      mem_expiry[waddr] <= w_expiry;
    end
    if (cmd.rd_en) begin
      rd_idx    <= idx;
      rd_live   <= mem_live[idx];
      rd_rpt    <= mem_rpt[idx];
      rd_gen    <= mem_gen[idx];
      rd_period <= mem_period[idx];
      rd_expiry <= mem_expiry[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_zero) begin
      idx <= '0;
    end else if (cmd.idx_del) begin
      idx <= req_slot32[IDX_W-1:0];
    end else if (cmd.rd_en || cmd.idx_step) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q <= req.action;
      dur_q <= COUNT_BITS'(dur_c);
      rpt_q <= req.repeat_req;
      tid_q <= req.timer_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (cmd.tick_step) begin
      tick_count <= tick_count + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (evt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_id   <= id_sel;
      out_kind <= cmd.kind;
      out_last <= cmd.last;
    end
  end

  assign evt.valid      = out_valid;
  assign evt.result_id  = out_id;
  assign evt.event_kind = out_kind;
  assign evt.last       = out_last;

  assign stat.in_valid  = req.valid;
  assign stat.in_act    = req.action;
  assign stat.act       = act_q;
  assign stat.live      = rd_live;
  assign stat.rpt       = rd_rpt;
  assign stat.hit       = (rd_expiry == tick_count);
  assign stat.gen_ok    = (32'(rd_gen) == (tid32 & GEN_MASK32));
  assign stat.slot_ok   = ((tid32 >> GEN_BITS) < 32'(MAX_TIMERS));
  assign stat.scan_last = (rd_idx == LAST_IDX);
  assign stat.clr_last  = (idx == LAST_IDX);
  assign stat.out_free  = !out_valid || evt.ready;

endmodule

`default_nettype wire

// ===== rtl/hierarchical_timer_wheel.sv =====
// hierarchical_timer_wheel: top level, joins the controller and the datapath.
// Depends on htw_pkg, htw_if, htw_ctrl and htw_dp.
//
// Timer service over MAX_TIMERS slots kept in a slot table with one read and one
// write port that is read one entry per cycle in a scan, unless an event word is
// held on evt. After reset the table is cleared entry by entry with req.ready low.
// A delete reads only its own slot, an add scans to the lowest free slot, and a
// tick scans every slot in turn. Every step that emits an event word waits while
// the previous word is still held on evt. The event output is registered, so the
// next request is taken while the final event of the previous one waits for
// evt.ready. Event words of one request arrive in order, the final one with last
// set; a tick reports expirations in ascending slot order, then tick done.
`default_nettype none

module hierarchical_timer_wheel import htw_pkg::*; #(
  parameter int MAX_TIMERS = MAX_TIMERS_DEF,
  parameter int GEN_BITS   = GEN_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  htw_in_if.sink    req,
  htw_out_if.source evt
);

  htw_cmd_t  cmd;
  htw_stat_t stat;

  htw_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  htw_dp #(
    .MAX_TIMERS (MAX_TIMERS),
    .GEN_BITS   (GEN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .evt  (evt),
    .cmd  (cmd),
    .stat (stat)
  );

  // never overwrite an event word that has not been taken
  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> stat.out_free)
    else $error("event word overwritten");

  // a slot is only claimed when the scanned entry is free
  assert property (@(posedge clk) disable iff (rst) (cmd.wr == WR_ALLOC) |-> !stat.live)
    else $error("live slot claimed");

  // a tick always scans, so no new request right after one is taken
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.action == ACT_TICK) |=> !req.ready)
    else $error("request taken during tick scan");

endmodule

`default_nettype wire
